@@ hdl/lc3ic_pkg.sv @@
// Package for the LC-3 instruction core: sequencer states, opcodes, trap vectors,
// result status codes, memory-mapped device addresses and small helper functions.
// Depends on nothing; the core top level and the testbench import it.
package lc3ic_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_REG1,
    S_REG2,
    S_EXEC,
    S_MEM1,
    S_LOAD,
    S_STI,
    S_TRAP0,
    S_STR_RD,
    S_STR_DAT,
    S_STR_HI
  } state_t;

  // Commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_EXEC    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Opcodes
  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  // Trap vectors
  localparam logic [7:0] TV_GETC  = 8'h20;
  localparam logic [7:0] TV_OUT   = 8'h21;
  localparam logic [7:0] TV_PUTS  = 8'h22;
  localparam logic [7:0] TV_IN    = 8'h23;
  localparam logic [7:0] TV_PUTSP = 8'h24;
  localparam logic [7:0] TV_HALT  = 8'h25;

  // Result status codes
  localparam logic [2:0] ST_EXECUTED = 3'd0;
  localparam logic [2:0] ST_HALTED   = 3'd1;
  localparam logic [2:0] ST_WAIT_KEY = 3'd2;
  localparam logic [2:0] ST_LOADED   = 3'd3;
  localparam logic [2:0] ST_RESERVED = 3'd4;
  localparam logic [2:0] ST_RESTART  = 3'd5;

  // Device registers
  localparam logic [15:0] ADDR_KBSR = 16'hFE00;
  localparam logic [15:0] ADDR_KBDR = 16'hFE02;
  localparam logic [15:0] ADDR_DSR  = 16'hFE04;
  localparam logic [15:0] ADDR_DDR  = 16'hFE06;

  localparam logic [15:0] START_RESET = 16'h3000;
  localparam logic [2:0]  FLAG_P = 3'd1;
  localparam logic [2:0]  FLAG_Z = 3'd2;
  localparam logic [2:0]  FLAG_N = 3'd4;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    if (v == 16'h0000) return FLAG_Z;
    else if (v[15]) return FLAG_N;
    else return FLAG_P;
  endfunction

  function automatic logic [15:0] sext5(input logic [15:0] w);
    return {{11{w[4]}}, w[4:0]};
  endfunction

  function automatic logic [15:0] sext6(input logic [15:0] w);
    return {{10{w[5]}}, w[5:0]};
  endfunction

  function automatic logic [15:0] sext9(input logic [15:0] w);
    return {{7{w[8]}}, w[8:0]};
  endfunction

  function automatic logic [15:0] sext11(input logic [15:0] w);
    return {{5{w[10]}}, w[10:0]};
  endfunction

endpackage

@@ hdl/lc3ic_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lc3ic_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/lc3_instruction_core_unit.sv @@
// Top level of the LC-3 instruction core: command sequencer, main memory and
// register file. Depends on lc3ic_pkg and lc3ic_ram.
//
// The core takes one command item at a time: start is sampled while busy is low.
// Each load, execute or restart command yields its results on the out_ ports, one
// cycle each, flagged by out_strobe; the receiver cannot stall, so every result
// must be taken as it appears. Load and restart finish in the cycle they are taken
// and leave busy low, so one can be taken every cycle; the result follows in the
// next cycle. An execute item holds busy through fetch, two register-file reads
// and execute, its result coming in the cycle after execute, so a new execute item
// is taken only once busy drops. LD/LDR add S_LOAD, LDI adds S_MEM1 and S_LOAD,
// STI adds S_STI and GETC/IN add S_TRAP0 for the R0 write. PUTS/PUTSP read each
// memory word in S_STR_RD and S_STR_DAT, plus S_STR_HI for a PUTSP word with a
// high byte, and emit one result per character, at most STRING_LIMIT. The steps
// are set by the single read port of the main memory and of the register file.
// After reset the core sweeps the whole main memory to zero, one word a cycle,
// holding busy high; configuration writes are taken even then.
module lc3_instruction_core_unit #(
  parameter int MEM_WORDS    = 65536,
  parameter int STRING_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_load_address,
  input  logic [15:0] in_load_data,
  input  logic        in_key_ready,
  input  logic [7:0]  in_key_char,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [15:0] out_pc_after,
  output logic [2:0]  out_flags,
  output logic [15:0] out_executed_word,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_key_taken,
  output logic        out_string_cut,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import lc3ic_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int NW = $clog2(STRING_LIMIT + 1);

  // Architectural and sequencing state
  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [15:0]   start_r;
  logic [15:0]   pc_r, pc_nxt;
  logic [2:0]    flags_r, flags_nxt;
  logic          run_r, run_nxt;

  // Per-item working registers
  logic          key_rdy_r, key_rdy_nxt;
  logic [7:0]    key_ch_r, key_ch_nxt;
  logic [15:0]   word_r, word_nxt;
  logic [15:0]   a_r, a_nxt;
  logic [15:0]   b_r, b_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic          key_hit_r, key_hit_nxt;
  logic          first_done_r, first_done_nxt;
  logic [NW-1:0] str_n_r, str_n_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          map_hit_r, map_hit_nxt;
  logic [15:0]   map_val_r, map_val_nxt;

  // Result register
  logic          strobe_r;
  logic [2:0]    status_r;
  logic [15:0]   pc_out_r;
  logic [2:0]    flags_out_r;
  logic [15:0]   word_out_r;
  logic          ov_r;
  logic [7:0]    ch_r;
  logic          kt_r;
  logic          cut_r;
  logic          last_r;

  // Emit request
  logic          em;
  logic [2:0]    em_status;
  logic          em_ov;
  logic [7:0]    em_ch;
  logic          em_cut;
  logic          em_last;

  // Memory ports
  logic          mem_we;
  logic [15:0]   mem_waddr, mem_wdata, mem_raddr, mem_rdata;
  logic          map_en;
  logic          rf_we;
  logic [2:0]    rf_waddr, rf_raddr;
  logic [15:0]   rf_wdata, rf_rdata;

  // String push
  logic          do_push;
  logic [7:0]    push_c;
  logic          push_more;

  logic          accept;
  logic          kr;
  logic [7:0]    kc;
  logic [15:0]   rdval;
  logic [3:0]    op;
  logic [7:0]    vec;
  logic [15:0]   res;

  lc3ic_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr[AW-1:0]),
    .rdata (mem_rdata)
  );

  lc3ic_ram #(.WIDTH(16), .DEPTH(8)) u_regs (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Key inputs: live at accept, latched afterwards
  assign kr = (state_r == S_IDLE) ? in_key_ready : key_rdy_r;
  assign kc = (state_r == S_IDLE) ? in_key_char : key_ch_r;

  // Read data as the program sees it: devices override memory
  assign rdval = map_hit_r ? map_val_r : mem_rdata;
  assign op    = word_r[15:12];
  assign vec   = word_r[7:0];

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    flags_nxt      = flags_r;
    run_nxt        = run_r;
    key_rdy_nxt    = key_rdy_r;
    key_ch_nxt     = key_ch_r;
    word_nxt       = word_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    addr_nxt       = addr_r;
    hi_nxt         = hi_r;
    key_hit_nxt    = key_hit_r;
    first_done_nxt = first_done_r;
    str_n_nxt      = str_n_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    em             = 1'b0;
    em_status      = ST_EXECUTED;
    em_ov          = 1'b0;
    em_ch          = 8'h00;
    em_cut         = 1'b0;
    em_last        = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = b_r;
    mem_raddr      = addr_r;
    map_en         = 1'b0;
    rf_we          = 1'b0;
    rf_waddr       = word_r[11:9];
    rf_wdata       = 16'h0000;
    rf_raddr       = word_r[8:6];
    do_push        = 1'b0;
    push_c         = 8'h00;
    push_more      = 1'b0;
    res            = 16'h0000;

    unique case (state_r)
      S_CLEAR: begin
        // Zero one memory word and one register per cycle
        mem_we    = 1'b1;
        mem_waddr = 16'(clr_cnt_r);
        mem_wdata = 16'h0000;
        rf_we     = 1'b1;
        rf_waddr  = clr_cnt_r[2:0];
        rf_wdata  = 16'h0000;
        if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          key_rdy_nxt    = in_key_ready;
          key_ch_nxt     = in_key_char;
          key_hit_nxt    = 1'b0;
          first_done_nxt = 1'b0;
          word_nxt       = 16'h0000;
          unique case (in_cmd)
            CMD_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = in_load_address;
              mem_wdata = in_load_data;
              em        = 1'b1;
              em_status = ST_LOADED;
            end
            CMD_RESTART: begin
              pc_nxt    = start_r;
              run_nxt   = 1'b1;
              em        = 1'b1;
              em_status = ST_RESTART;
            end
            CMD_EXEC: begin
              if (!run_r) begin
                em        = 1'b1;
                em_status = ST_HALTED;
              end else begin
                mem_raddr = pc_r;
                map_en    = 1'b1;
                state_nxt = S_FETCH;
              end
            end
            default: begin
              // Unused command: drop it
            end
          endcase
        end
      end

      S_FETCH: begin
        word_nxt  = rdval;
        pc_nxt    = pc_r + 16'd1;
        rf_raddr  = rdval[8:6];
        state_nxt = S_REG1;
      end

      S_REG1: begin
        a_nxt = rf_rdata;
        if (op == OP_ADD || op == OP_AND) begin
          rf_raddr = word_r[2:0];
        end else if (op == OP_TRAP) begin
          rf_raddr = 3'd0;
        end else begin
          rf_raddr = word_r[11:9];
        end
        state_nxt = S_REG2;
      end

      S_REG2: begin
        b_nxt     = rf_rdata;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (op)
          OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
            if (op == OP_ADD) begin
              res = a_r + (word_r[5] ? sext5(word_r) : b_r);
            end else if (op == OP_AND) begin
              res = a_r & (word_r[5] ? sext5(word_r) : b_r);
            end else if (op == OP_NOT) begin
              res = ~a_r;
            end else begin
              res = pc_r + sext9(word_r);
            end
            rf_we     = 1'b1;
            rf_wdata  = res;
            flags_nxt = nzp(res);
            em        = 1'b1;
          end
          OP_BR: begin
            if ((word_r[11:9] & flags_r) != 3'b000) begin
              pc_nxt = pc_r + sext9(word_r);
            end
            em = 1'b1;
          end
          OP_JMP: begin
            pc_nxt = a_r;
            em     = 1'b1;
          end
          OP_JSR: begin
            pc_nxt   = word_r[11] ? (pc_r + sext11(word_r)) : a_r;
            rf_we    = 1'b1;
            rf_waddr = 3'd7;
            rf_wdata = pc_r;
            em       = 1'b1;
          end
          OP_LD, OP_LDI, OP_LDR, OP_STI: begin
            mem_raddr = (op == OP_LDR) ? (a_r + sext6(word_r)) : (pc_r + sext9(word_r));
            map_en    = 1'b1;
            if (op == OP_LDI) begin
              state_nxt = S_MEM1;
            end else if (op == OP_STI) begin
              state_nxt = S_STI;
            end else begin
              state_nxt = S_LOAD;
            end
          end
          OP_ST, OP_STR: begin
            mem_we    = 1'b1;
            mem_waddr = (op == OP_STR) ? (a_r + sext6(word_r)) : (pc_r + sext9(word_r));
            mem_wdata = b_r;
            em        = 1'b1;
          end
          OP_TRAP: begin
            if ((vec == TV_GETC || vec == TV_IN) && !key_rdy_r) begin
              // No key: rewind to the TRAP and change nothing
              pc_nxt    = pc_r - 16'd1;
              em        = 1'b1;
              em_status = ST_WAIT_KEY;
            end else begin
              rf_we    = 1'b1;
              rf_waddr = 3'd7;
              rf_wdata = pc_r;
              if (vec == TV_GETC || vec == TV_IN) begin
                key_hit_nxt = 1'b1;
                state_nxt   = S_TRAP0;
              end else if (vec == TV_OUT) begin
                em    = 1'b1;
                em_ov = 1'b1;
                em_ch = b_r[7:0];
              end else if (vec == TV_PUTS || vec == TV_PUTSP) begin
                addr_nxt   = b_r;
                str_n_nxt  = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_STR_RD;
              end else if (vec == TV_HALT) begin
                run_nxt   = 1'b0;
                em        = 1'b1;
                em_status = ST_HALTED;
              end else begin
                em = 1'b1;
              end
            end
          end
          default: begin
            // RTI and the reserved opcode
            em        = 1'b1;
            em_status = ST_RESERVED;
          end
        endcase
      end

      S_MEM1: begin
        mem_raddr = rdval;
        map_en    = 1'b1;
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        rf_we     = 1'b1;
        rf_wdata  = rdval;
        flags_nxt = nzp(rdval);
        em        = 1'b1;
        state_nxt = S_IDLE;
      end

      S_STI: begin
        mem_we    = 1'b1;
        mem_waddr = rdval;
        mem_wdata = b_r;
        em        = 1'b1;
        state_nxt = S_IDLE;
      end

      S_TRAP0: begin
        rf_we     = 1'b1;
        rf_waddr  = 3'd0;
        rf_wdata  = {8'h00, key_ch_r};
        em        = 1'b1;
        em_ov     = (vec == TV_IN);
        em_ch     = (vec == TV_IN) ? key_ch_r : 8'h00;
        state_nxt = S_IDLE;
      end

      S_STR_RD: begin
        mem_raddr = addr_r;
        state_nxt = S_STR_DAT;
      end

      S_STR_DAT: begin
        if (mem_rdata == 16'h0000) begin
          // End of string: flush the held character or report an empty run
          em        = 1'b1;
          em_ov     = pend_v_r;
          em_ch     = pend_v_r ? pend_r : 8'h00;
          state_nxt = S_IDLE;
        end else begin
          do_push   = 1'b1;
          push_c    = mem_rdata[7:0];
          hi_nxt    = mem_rdata[15:8];
          push_more = (vec == TV_PUTSP) && (mem_rdata[15:8] != 8'h00);
        end
      end

      S_STR_HI: begin
        do_push = 1'b1;
        push_c  = hi_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // One character joins the run; the previous one goes out, not marked last (at the limit the held one goes out cut)
    if (do_push) begin
      if (str_n_r == NW'(STRING_LIMIT)) begin
        em        = 1'b1;
        em_ov     = 1'b1;
        em_ch     = pend_r;
        em_cut    = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        if (pend_v_r) begin
          em      = 1'b1;
          em_ov   = 1'b1;
          em_ch   = pend_r;
          em_last = 1'b0;
        end
        pend_nxt   = push_c;
        pend_v_nxt = 1'b1;
        str_n_nxt  = str_n_r + NW'(1);
        if (push_more) begin
          state_nxt = S_STR_HI;
        end else begin
          addr_nxt  = addr_r + 16'd1;
          state_nxt = S_STR_RD;
        end
      end
    end

    // Device registers on mapped reads
    map_hit_nxt = 1'b0;
    map_val_nxt = 16'h0000;
    if (map_en) begin
      if (mem_raddr == ADDR_KBSR) begin
        map_hit_nxt = 1'b1;
        map_val_nxt = kr ? 16'h8000 : 16'h0000;
      end else if (mem_raddr == ADDR_KBDR) begin
        map_hit_nxt = 1'b1;
        map_val_nxt = kr ? {8'h00, kc} : 16'h0000;
        if (kr) begin
          key_hit_nxt = 1'b1;
        end
      end else if (mem_raddr == ADDR_DSR) begin
        map_hit_nxt = 1'b1;
        map_val_nxt = 16'h8000;
      end else if (mem_raddr == ADDR_DDR) begin
        map_hit_nxt = 1'b1;
      end
    end

    if (em) begin
      first_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      start_r      <= START_RESET;
      pc_r         <= START_RESET;
      flags_r      <= FLAG_Z;
      run_r        <= 1'b1;
      strobe_r     <= 1'b0;
      first_done_r <= 1'b0;
      key_hit_r    <= 1'b0;
      pend_v_r     <= 1'b0;
      str_n_r      <= '0;
      map_hit_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_r + AW'(1);
      if (cfg_we) begin
        start_r <= cfg_data;
      end
      pc_r         <= pc_nxt;
      flags_r      <= flags_nxt;
      run_r        <= run_nxt;
      strobe_r     <= em;
      first_done_r <= first_done_nxt;
      key_hit_r    <= key_hit_nxt;
      pend_v_r     <= pend_v_nxt;
      str_n_r      <= str_n_nxt;
      map_hit_r    <= map_hit_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    key_rdy_r <= key_rdy_nxt;
    key_ch_r  <= key_ch_nxt;
    word_r    <= word_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    addr_r    <= addr_nxt;
    hi_r      <= hi_nxt;
    pend_r    <= pend_nxt;
    map_val_r <= map_val_nxt;
    if (em) begin
      status_r    <= em_status;
      pc_out_r    <= pc_nxt;
      flags_out_r <= flags_nxt;
      word_out_r  <= word_nxt;
      ov_r        <= em_ov;
      ch_r        <= em_ch;
      kt_r        <= key_hit_nxt && !first_done_r;
      cut_r       <= em_cut;
      last_r      <= em_last;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_pc_after      = pc_out_r;
  assign out_flags         = flags_out_r;
  assign out_executed_word = word_out_r;
  assign out_valid         = ov_r;
  assign out_char          = ch_r;
  assign out_key_taken     = kt_r;
  assign out_string_cut    = cut_r;
  assign out_last          = last_r;

`ifndef SYNTHESIS
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(flags_r)) else $error("condition flags not one-hot");

  a_cut_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && cut_r) |-> last_r) else $error("cut result not marked last");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !strobe_r) else $error("result during memory clear");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    str_n_r <= NW'(STRING_LIMIT)) else $error("string count past bound");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r != S_CLEAR)) else $error("item taken during clear");
`endif

endmodule

@@ bench/tb_lc3_instruction_core_unit.sv @@
// Testbench for lc3_instruction_core_unit: drives load, execute and restart items,
// predicts every result with its own copy of the core state and checks each one.
// Depends on lc3ic_pkg and the RTL of the core.
module tb_lc3_instruction_core_unit;
  import lc3ic_pkg::*;

  localparam int CHAR_LIMIT = 64;
  // Opcodes the package leaves unnamed: RTI and the reserved one.
  localparam logic [3:0] OP_RTI  = 4'h8;
  localparam logic [3:0] OP_RESV = 4'hD;

  typedef struct packed {
    bit [2:0]  status;
    bit [15:0] pc_after;
    bit [2:0]  flags;
    bit [15:0] word;
    bit        ch_valid;
    bit [7:0]  ch;
    bit        key_taken;
    bit        cut;
    bit        last;
  } core_result_t;

  // Shadow core: state of the LC-3 and the queue of results it still owes.
  class lc3_scoreboard;
    bit [15:0] mem [65536];
    bit [15:0] regs [8];
    bit [15:0] pc;
    bit [2:0]  flags;
    bit        running;
    bit [15:0] start_addr;
    bit [15:0] cur_word;
    bit        key_hit;
    core_result_t owed_q [$];
    int        errors;

    function void reset_state();
      foreach (mem[i]) mem[i] = 16'h0;
      foreach (regs[i]) regs[i] = 16'h0;
      start_addr = START_RESET;
      pc = START_RESET;
      flags = FLAG_Z;
      running = 1'b1;
      errors = 0;
    endfunction

    function bit [15:0] sx(bit [15:0] w, int bits);
      bit [15:0] m;
      bit [15:0] v;
      m = (16'h1 << bits) - 16'h1;
      v = w & m;
      if (v[bits-1]) v = v | ~m;
      return v;
    endfunction

    // Memory-mapped read: keyboard and display registers shadow plain memory.
    function bit [15:0] rd(bit [15:0] a, bit kr, bit [7:0] kc);
      case (a)
        ADDR_KBSR: return kr ? 16'h8000 : 16'h0;
        ADDR_KBDR: begin
          if (!kr) return 16'h0;
          key_hit = 1'b1;
          return {8'h0, kc};
        end
        ADDR_DSR: return 16'h8000;
        ADDR_DDR: return 16'h0;
        default: return mem[a];
      endcase
    endfunction

    function void setf(bit [15:0] v);
      flags = nzp_of(v);
    endfunction

    function bit [2:0] nzp_of(bit [15:0] v);
      if (v == 16'h0) return FLAG_Z;
      if (v[15]) return FLAG_N;
      return FLAG_P;
    endfunction

    function void owe(bit [2:0] st, bit ov, bit [7:0] ch, bit kt, bit cut, bit last);
      core_result_t r;
      r = '{st, pc, flags, cur_word, ov, ov ? ch : 8'h0, kt, cut, last};
      owed_q.push_back(r);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted item and queue the results it causes.
    function void note(bit [1:0] cmd, bit [15:0] la, bit [15:0] ld, bit kr, bit [7:0] kc);
      bit [15:0] w, pc0, t, a, m;
      bit [2:0]  dr, s1, st;
      bit        ov, cut;
      bit [7:0]  ch, vec;
      bit [7:0]  chars [$];
      st = ST_EXECUTED;
      ov = 1'b0;
      ch = 8'h0;
      cut = 1'b0;
      cur_word = 16'h0;
      key_hit = 1'b0;
      if (cmd == CMD_LOAD) begin
        mem[la] = ld;
        owe(ST_LOADED, 1'b0, 8'h0, 1'b0, 1'b0, 1'b1);
        return;
      end
      if (cmd == CMD_RESTART) begin
        pc = start_addr;
        running = 1'b1;
        owe(ST_RESTART, 1'b0, 8'h0, 1'b0, 1'b0, 1'b1);
        return;
      end
      if (cmd != CMD_EXEC) return;
      if (!running) begin
        owe(ST_HALTED, 1'b0, 8'h0, 1'b0, 1'b0, 1'b1);
        return;
      end
      pc0 = pc;
      w = rd(pc0, kr, kc);
      cur_word = w;
      pc = pc0 + 16'h1;
      dr = w[11:9];
      s1 = w[8:6];
      case (w[15:12])
        OP_ADD, OP_AND: begin
          t = w[5] ? sx(w, 5) : regs[w[2:0]];
          regs[dr] = (w[15:12] == OP_ADD) ? regs[s1] + t : regs[s1] & t;
          setf(regs[dr]);
        end
        OP_NOT: begin
          regs[dr] = ~regs[s1];
          setf(regs[dr]);
        end
        OP_BR: if ((w[11:9] & flags) != 3'b0) pc = pc + sx(w, 9);
        OP_JMP: pc = regs[s1];
        OP_JSR: begin
          t = w[11] ? pc + sx(w, 11) : regs[s1];
          regs[7] = pc;
          pc = t;
        end
        OP_LD: begin
          regs[dr] = rd(pc + sx(w, 9), kr, kc);
          setf(regs[dr]);
        end
        OP_LDI: begin
          t = rd(pc + sx(w, 9), kr, kc);
          regs[dr] = rd(t, kr, kc);
          setf(regs[dr]);
        end
        OP_LDR: begin
          regs[dr] = rd(regs[s1] + sx(w, 6), kr, kc);
          setf(regs[dr]);
        end
        OP_LEA: begin
          regs[dr] = pc + sx(w, 9);
          setf(regs[dr]);
        end
        OP_ST: begin
          t = pc + sx(w, 9);
          mem[t] = regs[dr];
        end
        OP_STI: begin
          t = rd(pc + sx(w, 9), kr, kc);
          mem[t] = regs[dr];
        end
        OP_STR: begin
          t = regs[s1] + sx(w, 6);
          mem[t] = regs[dr];
        end
        OP_TRAP: begin
          vec = w[7:0];
          if ((vec == TV_GETC || vec == TV_IN) && !kr) begin
            // No key yet: hold the PC on the trap so it is retried.
            pc = pc0;
            st = ST_WAIT_KEY;
          end else begin
            regs[7] = pc;
            if (vec == TV_GETC || vec == TV_IN) begin
              regs[0] = {8'h0, kc};
              key_hit = 1'b1;
              if (vec == TV_IN) begin
                ov = 1'b1;
                ch = kc;
              end
            end else if (vec == TV_OUT) begin
              ov = 1'b1;
              ch = regs[0][7:0];
            end else if (vec == TV_PUTS || vec == TV_PUTSP) begin
              a = regs[0];
              forever begin
                m = mem[a];
                if (m == 16'h0) break;
                if (chars.size() == CHAR_LIMIT) begin
                  cut = 1'b1;
                  break;
                end
                chars.push_back(m[7:0]);
                if (vec == TV_PUTSP && m[15:8] != 8'h0) begin
                  if (chars.size() == CHAR_LIMIT) begin
                    cut = 1'b1;
                    break;
                  end
                  chars.push_back(m[15:8]);
                end
                a = a + 16'h1;
              end
              if (chars.size() == 0) begin
                owe(ST_EXECUTED, 1'b0, 8'h0, key_hit, cut, 1'b1);
                return;
              end
              foreach (chars[i])
                owe(ST_EXECUTED, 1'b1, chars[i], (i == 0) ? key_hit : 1'b0,
                    (i == chars.size() - 1) ? cut : 1'b0, i == chars.size() - 1);
              return;
            end else if (vec == TV_HALT) begin
              running = 1'b0;
              st = ST_HALTED;
            end
          end
        end
        default: st = ST_RESERVED;
      endcase
      owe(st, ov, ch, key_hit, 1'b0, 1'b1);
    endfunction

    function void check(core_result_t got);
      core_result_t exp;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: unexpected result status=%0d pc=%h word=%h char=%h",
                   got.status, got.pc_after, got.word, got.ch);
        return;
      end
      exp = owed_q.pop_front();
      if (exp != got) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: status exp %0d got %0d, pc exp %h got %h, flags exp %0d got %0d",
                   exp.status, got.status, exp.pc_after, got.pc_after, exp.flags, got.flags);
          $display("  word exp %h got %h, char exp %b/%h got %b/%h, key exp %b got %b",
                   exp.word, got.word, exp.ch_valid, exp.ch, got.ch_valid, got.ch,
                   exp.key_taken, got.key_taken);
          $display("  cut exp %b got %b, last exp %b got %b",
                   exp.cut, got.cut, exp.last, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = CMD_LOAD;
  logic [15:0] in_load_address = 16'h0;
  logic [15:0] in_load_data = 16'h0;
  logic        in_key_ready = 1'b0;
  logic [7:0]  in_key_char = 8'h0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [15:0] out_pc_after;
  logic [2:0]  out_flags;
  logic [15:0] out_executed_word;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_key_taken;
  logic        out_string_cut;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'h0;

  lc3_scoreboard sb = new();
  int          n_items = 0;
  bit          idle_on = 1'b1;
  bit [15:0]   cur_start = START_RESET;

  lc3_instruction_core_unit #(.MEM_WORDS(65536), .STRING_LIMIT(CHAR_LIMIT)) DUT (
    .clk, .rst_n, .start, .busy,
    .in_cmd, .in_load_address, .in_load_data, .in_key_ready, .in_key_char,
    .out_strobe, .out_status, .out_pc_after, .out_flags, .out_executed_word,
    .out_valid, .out_char, .out_key_taken, .out_string_cut, .out_last,
    .cfg_we, .cfg_data
  );

  always #6 clk = ~clk;

  // Sample at the rising edge: note accepted items first, then check results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note(in_cmd, in_load_address, in_load_data, in_key_ready, in_key_char);
      if (out_strobe)
        sb.check('{out_status, out_pc_after, out_flags, out_executed_word, out_valid,
                   out_char, out_key_taken, out_string_cut, out_last});
    end
  end

  // Hand one item to the core; hold start high until busy is low at an edge.
  task automatic send_item(bit [1:0] cmd, bit [15:0] la, bit [15:0] ld, bit kr,
                           bit [7:0] kc);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    start = 1'b1;
    in_cmd = cmd;
    in_load_address = la;
    in_load_data = ld;
    in_key_ready = kr;
    in_key_char = kc;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  task automatic load_word(bit [15:0] a, bit [15:0] d);
    send_item(CMD_LOAD, a, d, 1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic exec_one(bit kr, bit [7:0] kc);
    send_item(CMD_EXEC, 16'($urandom), 16'($urandom), kr, kc);
  endtask

  task automatic restart_core();
    send_item(CMD_RESTART, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
              8'($urandom));
  endtask

  // Drop start and wait until every owed result has come, then let the core settle.
  task automatic drain();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_start(bit [15:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.start_addr = v;
    cur_start = v;
  endtask

  function automatic bit [15:0] rand_insn();
    bit [3:0]  op;
    bit [11:0] rest;
    int        k;
    op = 4'($urandom_range(0, 15));
    if ((op == OP_RTI || op == OP_RESV) && $urandom_range(0, 3) != 0) op = OP_ADD;
    rest = 12'($urandom);
    if (op == OP_TRAP) begin
      k = $urandom_range(0, 19);
      if (k < 3) rest[7:0] = TV_PUTS;
      else if (k < 6) rest[7:0] = TV_PUTSP;
      else if (k < 8) rest[7:0] = TV_OUT;
      else if (k < 10) rest[7:0] = TV_GETC;
      else if (k < 12) rest[7:0] = TV_IN;
      else if (k == 12) rest[7:0] = TV_HALT;
    end
    // Keep most PC-relative jumps near the program.
    if ((op == OP_BR || op == OP_JSR) && $urandom_range(0, 1) == 1) begin
      rest[8:0] = 9'($urandom_range(0, 4));
      rest[10:9] = 2'b11;
    end
    return {op, rest};
  endfunction

  // One well-formed program: point R0 at a string, random instructions, the
  // string and its terminator, then restart and run it.
  task automatic run_program();
    int        n, len;
    bit [15:0] base, d;
    base = cur_start;
    n = $urandom_range(3, 10);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 5);
    load_word(base, {OP_LEA, 3'd0, 9'(n)});
    for (int i = 1; i <= n; i++) load_word(base + 16'(i), rand_insn());
    for (int j = 0; j < len; j++) begin
      if (len > 30) d = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
      else d = 16'($urandom);
      if (d == 16'h0) d = 16'h1;
      load_word(base + 16'(n + 1 + j), d);
    end
    load_word(base + 16'(n + 1 + len), 16'h0);
    if ($urandom_range(0, 4) == 0) load_word(16'($urandom), 16'($urandom));
    restart_core();
    repeat (n + 3) exec_one($urandom_range(0, 2) != 0, 8'($urandom));
    if ($urandom_range(0, 5) == 0) exec_one(1'($urandom), 8'($urandom));
  endtask

  initial begin
    bit [15:0] cfg_vals [5];
    int        blk;
    sb.reset_state();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    // Hold off until the memory clearing pass is over.
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed: device reads, key waits, empty string, reserved op, halt.
    load_word(16'h3000, 16'h1270);   // ADD R1,R1,#-16
    load_word(16'h3001, 16'hA40E);   // LDI R2 through the KBDR pointer
    load_word(16'h3002, 16'hF020);   // GETC
    load_word(16'h3003, 16'hF022);   // PUTS of an empty string
    load_word(16'h3004, 16'hD000);   // reserved opcode
    load_word(16'h3005, 16'hF025);   // HALT
    load_word(16'h3010, ADDR_KBDR);
    exec_one(1'b0, 8'h00);
    exec_one(1'b1, 8'hFF);
    exec_one(1'b0, 8'h00);
    exec_one(1'b1, 8'h80);
    exec_one(1'b0, 8'h00);
    exec_one(1'b0, 8'h00);
    exec_one(1'b0, 8'h00);
    exec_one(1'b1, 8'h7F);           // still halted
    restart_core();

    // Random programs under a rotating start address, extremes included.
    cfg_vals = '{16'h0000, 16'hFFFF, 16'hFE00, 16'h0000, START_RESET};
    blk = 0;
    while (n_items < 360) begin
      if (blk % 6 == 0) begin
        cfg_vals[3] = 16'($urandom);
        write_start(cfg_vals[(blk / 6) % 5]);
        restart_core();
        // Walk through the device registers when starting there.
        if (cur_start == 16'hFE00)
          repeat (8) exec_one(1'($urandom_range(0, 1)), 8'($urandom));
      end
      idle_on = (n_items < 290);
      run_program();
      blk++;
    end

    drain();
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ lc3_instruction_core_unit.f @@
hdl/lc3ic_pkg.sv
hdl/lc3ic_ram.sv
hdl/lc3_instruction_core_unit.sv
bench/tb_lc3_instruction_core_unit.sv
